@@ rtl/lprl_pkg.sv @@
// Shared types and constants for the longest-prefix route lookup block.
// Holds the request, result and queue item structs and the operation codes.
// No dependencies.
package lprl_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEFAULT = 16;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Command field codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Operation carried through the queue
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    // Input item
    typedef struct packed {
        logic        command;
        logic [3:0]  entry_slot;
        logic [31:0] entry_prefix;
        logic [31:0] entry_netmask;
        logic [31:0] entry_gateway;
        logic [1:0]  entry_port;
        logic        entry_enable;
        logic [31:0] lookup_address;
    } request_t;

    // Result item
    typedef struct packed {
        logic        route_found;
        logic [1:0]  out_port;
        logic [31:0] next_hop;
        logic [31:0] best_netmask;
    } result_t;

    // Classified item held in the queue
    typedef struct packed {
        op_t         op;
        logic [3:0]  slot;
        logic [31:0] prefix;
        logic [31:0] netmask;
        logic [31:0] gateway;
        logic [1:0]  port;
        logic        enable;
        logic [31:0] address;
    } queue_item_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

@@ rtl/lprl_front.sv @@
// Front end: accepts items and classifies them for the back end.
// Depends on lprl_pkg.
module lprl_front #(
    parameter int TABLE_ENTRIES = lprl_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                  start,
    input  lprl_pkg::request_t    request,
    input  lprl_pkg::queue_status_t q_status,
    output logic                  busy,
    output logic                  push,
    output lprl_pkg::queue_item_t push_item
);

    localparam logic [31:0] ENTRIES_W = 32'(TABLE_ENTRIES);

    logic slot_ok;

    // Hold off while the queue has no room
    assign busy = q_status.full;
    assign push = start && !busy;

    // Writes beyond the table are dropped here
    assign slot_ok = 32'(request.entry_slot) < ENTRIES_W;

    always_comb
    begin
        push_item.slot    = request.entry_slot;
        push_item.prefix  = request.entry_prefix;
        push_item.netmask = request.entry_netmask;
        push_item.gateway = request.entry_gateway;
        push_item.port    = request.entry_port;
        push_item.enable  = request.entry_enable;
        push_item.address = request.lookup_address;
        if (request.command == lprl_pkg::CMD_LOOKUP)
        begin
            push_item.op = lprl_pkg::OP_LOOKUP;
        end
        else if (slot_ok)
        begin
            push_item.op = lprl_pkg::OP_WRITE;
        end
        else
        begin
            push_item.op = lprl_pkg::OP_NONE;
        end
    end

endmodule

@@ rtl/lprl_queue.sv @@
// Short FIFO of classified items between front and back end.
// Depends on lprl_pkg.
module lprl_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  lprl_pkg::queue_item_t   push_item,
    input  logic                    pop,
    output lprl_pkg::queue_item_t   head,
    output lprl_pkg::queue_status_t status
);

    localparam int PW = lprl_pkg::QUEUE_PTR_W;
    localparam int CW = lprl_pkg::QUEUE_CNT_W;

    lprl_pkg::queue_item_t slot_reg [lprl_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CW'(lprl_pkg::QUEUE_DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slot_reg[rd_ptr_reg];

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(lprl_pkg::QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(lprl_pkg::QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

@@ rtl/lprl_back.sv @@
// Back end: route table storage and the one-entry-a-cycle lookup scan.
// Depends on lprl_pkg.
module lprl_back #(
    parameter int TABLE_ENTRIES = lprl_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lprl_pkg::queue_item_t   head,
    input  lprl_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic                    done,
    output lprl_pkg::result_t       result
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef struct packed {
        logic [31:0] prefix;
        logic [31:0] netmask;
        logic [31:0] gateway;
        logic [1:0]  port;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    entry_t              table_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;

    state_t      state_reg;
    state_t      state_next;
    logic [IW-1:0] scan_reg;
    logic        scan_last;
    logic [31:0] addr_reg;

    entry_t      rd_entry_reg;
    logic        rd_valid_reg;
    logic        cmp_en_reg;

    logic        hit_reg;
    logic [31:0] lead_mask_reg;
    logic [31:0] best_gw_reg;
    logic [1:0]  best_port_reg;
    logic        match;
    logic        better;
    logic        do_write;
    logic [IW-1:0] wr_idx;

    logic        done_reg;
    lprl_pkg::result_t result_reg;

    assign pop       = (state_reg == ST_IDLE) && !q_status.empty;
    assign do_write  = pop && (head.op == lprl_pkg::OP_WRITE);
    assign wr_idx    = IW'(head.slot);
    assign scan_last = (scan_reg == IW'(TABLE_ENTRIES - 1));
    assign done      = done_reg;
    assign result    = result_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop && (head.op == lprl_pkg::OP_LOOKUP))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Table memory: write from the queue head, registered read at the scan index
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            table_mem[wr_idx] <= '{prefix:  head.prefix,
                                   netmask: head.netmask,
                                   gateway: head.gateway,
                                   port:    head.port};
        end
        rd_entry_reg <= table_mem[scan_reg];
    end

    // Compare stage on the entry read last cycle
    assign match  = rd_valid_reg &&
                    ((addr_reg & rd_entry_reg.netmask) ==
                     (rd_entry_reg.prefix & rd_entry_reg.netmask));
    assign better = match && (!hit_reg || (rd_entry_reg.netmask > lead_mask_reg));

    // Lookup address and running best, payload only
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            addr_reg <= head.address;
        end
        if (cmp_en_reg && better)
        begin
            lead_mask_reg <= rd_entry_reg.netmask;
            best_gw_reg   <= rd_entry_reg.gateway;
            best_port_reg <= rd_entry_reg.port;
        end
        if (state_reg == ST_DONE)
        begin
            if (hit_reg)
            begin
                result_reg.route_found  <= 1'b1;
                result_reg.out_port     <= best_port_reg;
                result_reg.next_hop     <= (best_gw_reg == '0) ? addr_reg : best_gw_reg;
                result_reg.best_netmask <= lead_mask_reg;
            end
            else
            begin
                result_reg <= '0;
            end
        end
    end

    // Control state and valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_reg     <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            cmp_en_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= valid_reg[scan_reg];
            cmp_en_reg   <= (state_reg == ST_SCAN);
            done_reg     <= (state_reg == ST_DONE);
            if (do_write)
            begin
                valid_reg[wr_idx] <= head.enable;
            end
            if (state_reg == ST_SCAN)
            begin
                scan_reg <= scan_last ? '0 : scan_reg + IW'(1);
            end
            else
            begin
                scan_reg <= '0;
            end
            if (pop)
            begin
                hit_reg <= 1'b0;
            end
            else if (cmp_en_reg && better)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

endmodule

@@ rtl/longest_prefix_route_lookup.sv @@
// IPv4 route table with longest-prefix-match lookup, top level.
// Depends on lprl_pkg, lprl_front, lprl_queue and lprl_back.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. The
//   command field picks a table write (no result) or a lookup (one result).
//   Items pass through a two-deep queue, so busy rises only when the queue
//   is full; the front keeps taking items while the back end scans.
//   A lookup result shows on result for one cycle with done high; the
//   receiver cannot stall it and must take it in that cycle.
// Sequencing:
//   A write is applied as it leaves the queue and the back end stays idle. A
//   lookup scans one entry a cycle via the registered memory read, then
//   passes a drain state and a done state before done rises; the back end
//   takes no further item from the queue until it is idle again.
// Reset:
//   rst_n clears the queue, the sequencer and every valid bit, so the
//   table starts empty and every lookup misses until entries are written.
module longest_prefix_route_lookup #(
    parameter int TABLE_ENTRIES = lprl_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lprl_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output lprl_pkg::result_t  result
);

    logic                    push;
    logic                    pop;
    lprl_pkg::queue_item_t   push_item;
    lprl_pkg::queue_item_t   head;
    lprl_pkg::queue_status_t q_status;

    // Accept and classify
    lprl_front #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_front (
        .start     (start),
        .request   (request),
        .q_status  (q_status),
        .busy      (busy),
        .push      (push),
        .push_item (push_item)
    );

    // Decoupling queue
    lprl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // Table and scan
    lprl_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .done     (done),
        .result   (result)
    );

`ifndef SYNTHESIS
    // Back end only takes items that are there
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // A result strobe lasts one cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // No result can follow a dequeue in the next cycle
    a_pop_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> !done)
        else $error("result right after dequeue");
`endif

endmodule
